// ===== hdl/gcsl_pkg.sv =====
// gcsl_pkg: shared types and constants for the G-code comment strip tokenizer.
// Used by gcsl_lex, gcsl_outq and gcode_comment_strip_tokenizer; no dependencies.
`default_nettype none

package gcsl_pkg;

    // default nesting limit for parenthesis comments
    localparam int NEST_MAX = 15;

    // byte codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // paren_error codes
    localparam logic [1:0] PERR_NONE     = 2'd0;
    localparam logic [1:0] PERR_CLOSE    = 2'd1;
    localparam logic [1:0] PERR_UNCLOSED = 2'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       word_start;
        logic       line_end;
        logic       out_last;
        logic [1:0] paren_error;
    } out_item_t;

    function automatic out_item_t make_item(input logic [7:0] ch, input logic valid,
                                            input logic ws, input logic le,
                                            input logic [1:0] err);
        out_item_t r;
        r.out_char    = ch;
        r.char_valid  = valid;
        r.word_start  = ws;
        r.line_end    = le;
        r.out_last    = 1'b0;
        r.paren_error = err;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gcode_comment_strip_tokenizer.sv =====
// gcode_comment_strip_tokenizer: byte-serial G-code cleaner, top level.
// Depends on gcsl_pkg, gcsl_lex and gcsl_outq.
//
// Usage:
//   Raw program bytes enter on the byte channel (byte_valid/byte_ready,
//   byte_data = in_char, in_last). Cleaned bytes leave on the tok channel
//   (tok_valid/tok_ready, tok_data). Each byte gives zero, one or two items;
//   the byte flagged in_last always gives at least one, the last carrying
//   out_last and the final parenthesis status.
//   Items are written into the result queue as their byte is accepted.
//   Throughput: one byte per cycle while byte_ready is high; output drains
//   one item per cycle while tok_ready is high. The four-entry result
//   queue sets this: byte_ready is high while at most two items are queued.
//   Receiver stall: items wait in the queue; once it holds three or more,
//   byte_ready drops until the receiver takes items.
//   Reset: lexer state returns to start of program (depth 0, line start),
//   queue empties. State also returns to this after each in_last byte.
`default_nettype none

module gcode_comment_strip_tokenizer #(
    parameter int MAX_NEST = gcsl_pkg::NEST_MAX
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_ready,
    input  wire gcsl_pkg::in_item_t   byte_data,
    output logic                      tok_valid,
    input  wire logic                 tok_ready,
    output gcsl_pkg::out_item_t       tok_data
);

    logic                take;
    logic [1:0]          res_cnt;
    logic [1:0]          push_cnt;
    gcsl_pkg::out_item_t res0, res1;
    logic                room;

    assign byte_ready = room;
    assign take       = byte_valid && room;
    assign push_cnt   = take ? res_cnt : 2'd0;

    gcsl_lex #(
        .MAX_NEST (MAX_NEST)
    ) u_lex (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .item    (byte_data),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    gcsl_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

endmodule

`default_nettype wire

// ===== hdl/gcsl_lex.sv =====
// gcsl_lex: lexer state registers and the per-byte next-state / result logic.
// Depends on gcsl_pkg. Produces up to two result items per accepted byte.
`default_nettype none

module gcsl_lex #(
    parameter int MAX_NEST = gcsl_pkg::NEST_MAX
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire gcsl_pkg::in_item_t  item,
    output gcsl_pkg::out_item_t      res0,
    output gcsl_pkg::out_item_t      res1,
    output logic [1:0]               res_cnt
);

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam logic [DW-1:0] NEST_TOP = DW'(MAX_NEST);

    logic [DW-1:0] depth_reg, depth_next;
    logic          lcom_reg, lcom_next;
    logic          pct_reg, pct_next;
    logic          nlrun_reg, nlrun_next;
    logic          lstart_reg, lstart_next;

    gcsl_pkg::out_item_t slot [2];
    logic [1:0]          n;
    logic [7:0]          c;
    logic                upper;

    always_comb
    begin
        c           = item.in_char;
        upper       = (c >= gcsl_pkg::CH_UPPER_A) && (c <= gcsl_pkg::CH_UPPER_Z);
        depth_next  = depth_reg;
        lcom_next   = lcom_reg;
        pct_next    = pct_reg;
        nlrun_next  = nlrun_reg;
        lstart_next = lstart_reg;
        n           = 2'd0;
        slot[0]     = gcsl_pkg::make_item(8'h00, 1'b0, 1'b0, 1'b0, gcsl_pkg::PERR_NONE);
        slot[1]     = slot[0];

        if (c == gcsl_pkg::CH_OPEN) begin
            if (depth_reg < NEST_TOP)
                depth_next = depth_reg + 1'b1;
        end else if (c == gcsl_pkg::CH_CLOSE) begin
            if (depth_reg != '0) begin
                depth_next = depth_reg - 1'b1;
            end else begin
                if (pct_next) begin
                    pct_next    = 1'b0;
                    slot[n[0]]  = gcsl_pkg::make_item(gcsl_pkg::CH_PERCENT, 1'b1,
                                      lstart_next, 1'b0, gcsl_pkg::PERR_NONE);
                    n           = n + 2'd1;
                    lstart_next = 1'b0;
                end
                slot[n[0]]  = gcsl_pkg::make_item(c, 1'b1, lstart_next, 1'b0,
                                                  gcsl_pkg::PERR_CLOSE);
                n           = n + 2'd1;
                lstart_next = 1'b0;
                nlrun_next  = 1'b0;
            end
        end else if (depth_reg != '0) begin
            // inside a parenthesis comment
        end else if (lcom_reg && (c != gcsl_pkg::CH_LF)) begin
            // inside a semicolon comment
        end else if (c == gcsl_pkg::CH_SEMI) begin
            lcom_next = 1'b1;
        end else if ((c == gcsl_pkg::CH_SPACE) || (c == gcsl_pkg::CH_TAB) ||
                     (c == gcsl_pkg::CH_CR)) begin
            // white space dropped
        end else if (c == gcsl_pkg::CH_LF) begin
            lcom_next = 1'b0;
            if (pct_reg) begin
                // percent followed by newline: both vanish
                pct_next   = 1'b0;
                nlrun_next = 1'b1;
            end else if (!nlrun_reg) begin
                slot[0]     = gcsl_pkg::make_item(c, 1'b1, 1'b0, 1'b1, gcsl_pkg::PERR_NONE);
                n           = 2'd1;
                nlrun_next  = 1'b1;
                lstart_next = 1'b1;
            end
        end else begin
            if (pct_reg) begin
                slot[0]     = gcsl_pkg::make_item(gcsl_pkg::CH_PERCENT, 1'b1,
                                  lstart_reg, 1'b0, gcsl_pkg::PERR_NONE);
                n           = 2'd1;
                lstart_next = 1'b0;
                nlrun_next  = 1'b0;
                pct_next    = 1'b0;
            end
            if (c == gcsl_pkg::CH_PERCENT) begin
                pct_next   = 1'b1;
                nlrun_next = 1'b0;
            end else begin
                slot[n[0]]  = gcsl_pkg::make_item(c, 1'b1, lstart_next | upper, 1'b0,
                                                  gcsl_pkg::PERR_NONE);
                n           = n + 2'd1;
                lstart_next = 1'b0;
                nlrun_next  = 1'b0;
            end
        end

        if (item.in_last) begin
            if (pct_next) begin
                slot[n[0]] = gcsl_pkg::make_item(gcsl_pkg::CH_PERCENT, 1'b1,
                                 lstart_next, 1'b0, gcsl_pkg::PERR_NONE);
                n          = n + 2'd1;
            end
            if (n == 2'd0) begin
                // empty end marker
                n = 2'd1;
            end
            slot[n[0] ^ 1'b1].out_last = 1'b1;
            if (depth_next != '0)
                slot[n[0] ^ 1'b1].paren_error = gcsl_pkg::PERR_UNCLOSED;
            depth_next  = '0;
            lcom_next   = 1'b0;
            pct_next    = 1'b0;
            nlrun_next  = 1'b0;
            lstart_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            depth_reg  <= '0;
            lcom_reg   <= 1'b0;
            pct_reg    <= 1'b0;
            nlrun_reg  <= 1'b0;
            lstart_reg <= 1'b1;
        end else if (take) begin
            depth_reg  <= depth_next;
            lcom_reg   <= lcom_next;
            pct_reg    <= pct_next;
            nlrun_reg  <= nlrun_next;
            lstart_reg <= lstart_next;
        end
    end

    assign res0    = slot[0];
    assign res1    = slot[1];
    assign res_cnt = n;

endmodule

`default_nettype wire

// ===== hdl/gcsl_outq.sv =====
// gcsl_outq: four-entry result queue, takes up to two items per cycle, hands out one.
// Depends on gcsl_pkg.
`default_nettype none

module gcsl_outq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           push_cnt,
    input  wire gcsl_pkg::out_item_t  push0,
    input  wire gcsl_pkg::out_item_t  push1,
    output logic                      room,
    output logic                      tok_valid,
    input  wire logic                 tok_ready,
    output gcsl_pkg::out_item_t       tok_data
);

    gcsl_pkg::out_item_t mem [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = tok_valid && tok_ready;
    assign tok_valid = (cnt_reg != 3'd0);
    assign tok_data  = mem[rd_reg];
    // room for a worst-case two-item push regardless of this cycle's pop
    assign room      = (cnt_reg <= 3'd2);
    assign cnt_next  = cnt_reg + {1'b0, push_cnt} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[wr_reg + 2'd1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wr_reg  <= wr_reg + push_cnt;
            rd_reg  <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire
